// File: rtl/pcms16_pkg.sv
`default_nettype none
package pcms16_pkg;

    typedef enum logic [1:0] {
        FMT_S16   = 2'd0,
        FMT_S24   = 2'd1,
        FMT_S32   = 2'd2,
        FMT_FLOAT = 2'd3
    } t_fmt;

    localparam int          SAMPLE_W   = 32;
    localparam int          PCM_W      = 16;
    localparam int          SIG_W      = 24;
    localparam int          SH_W       = 5;
    localparam logic [7:0]  EXP_SPECIAL = 8'hFF;
    // Biased exponent of 1.0: anything at or above this is full scale.
    localparam logic [7:0]  EXP_ONE    = 8'd127;
    // At or below this exponent the scaled magnitude is under one half.
    localparam logic [7:0]  EXP_TINY   = 8'd110;
    // Shift of the 24-bit significand that leaves one fraction bit.
    localparam logic [7:0]  SHIFT_BASE = 8'd134;
    localparam logic [15:0] PCM_MAX    = 16'h7FFF;
    localparam logic [15:0] PCM_MIN    = 16'h8000;

    // Result of the decode stage.
    typedef struct packed {
        logic              is_float;  // rounding still to do
        logic              sign;
        logic [SIG_W-1:0]  sig;
        logic [SH_W-1:0]   sh;
        logic [PCM_W-1:0]  direct;    // final value when not is_float
        logic              silent;
        logic              last;
    } t_s1;

endpackage
`default_nettype wire

// File: rtl/pcms16_decode.sv
`default_nettype none
module pcms16_decode (
    input  wire logic [pcms16_pkg::SAMPLE_W-1:0] i_bits,
    input  wire pcms16_pkg::t_fmt                i_fmt,
    input  wire logic                            i_silent,
    input  wire logic                            i_last,
    output pcms16_pkg::t_s1                      o_dec
);

    logic [7:0] w_exp;
    logic [7:0] w_sh;

    assign w_exp = i_bits[30:23];
    assign w_sh  = pcms16_pkg::SHIFT_BASE - w_exp;

    always_comb begin
        o_dec.is_float = 1'b0;
        o_dec.sign     = i_bits[31];
        o_dec.sig      = {1'b1, i_bits[22:0]};
        o_dec.sh       = w_sh[pcms16_pkg::SH_W-1:0];
        o_dec.direct   = '0;
        o_dec.silent   = i_silent;
        o_dec.last     = i_last;
        case (i_fmt)
            pcms16_pkg::FMT_S16: begin
                o_dec.direct = i_bits[15:0];
            end
            pcms16_pkg::FMT_S24: begin
                o_dec.direct = i_bits[23:8];
            end
            pcms16_pkg::FMT_S32: begin
                o_dec.direct = i_bits[31:16];
            end
            default: begin
                if (w_exp == pcms16_pkg::EXP_SPECIAL) begin
                    o_dec.direct = '0;
                end else if (w_exp >= pcms16_pkg::EXP_ONE) begin
                    o_dec.direct = i_bits[31] ? pcms16_pkg::PCM_MIN : pcms16_pkg::PCM_MAX;
                end else if (w_exp <= pcms16_pkg::EXP_TINY) begin
                    o_dec.direct = '0;
                end else begin
                    o_dec.is_float = 1'b1;
                end
            end
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/pcm_to_s16_converter.sv
`default_nettype none
// Channel   | valid    | stall    | payload
// ----------+----------+----------+-------------------------------------------
// input     | i_valid  | o_stall  | i_sample_bits, i_silent, i_last_in_packet
// output    | o_valid  | i_stall  | o_pcm16, o_last_in_packet_res
// config    | i_cfg_we | -        | i_cfg_wdata (sample format)
//
// Each item passes three register stages: decode, significand shift, and
// round/saturate/negate. One item is taken per clock while o_stall is low.
// The whole pipeline advances together unless the output stage holds
// an item that is stalled, so nothing is dropped or repeated. Reset is
// synchronous and clears the valid bits and the format register (s16).
module pcm_to_s16_converter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_wdata,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_sample_bits,
    input  wire logic        i_silent,
    input  wire logic        i_last_in_packet,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic signed [15:0] o_pcm16,
    output logic             o_last_in_packet_res
);

    pcms16_pkg::t_fmt r_fmt;

    pcms16_pkg::t_s1 w_dec;
    pcms16_pkg::t_s1 r_s1;
    logic            r_v1;

    // Stage 2 keeps the shifted significand: one fraction bit below the
    // integer magnitude, which fits in 16 bits since the shift is at least 8.
    logic [15:0]     r_q;
    logic            r_v2;
    logic            r_f2;
    logic            r_sign2;
    logic [15:0]     r_direct2;
    logic            r_silent2;
    logic            r_last2;

    logic            r_v3;
    logic [15:0]     r_pcm;
    logic            r_last3;

    logic            w_en;
    logic [23:0]     w_shifted;
    logic [16:0]     w_sum;
    logic [15:0]     w_mag;
    logic [15:0]     w_res;

    assign w_en    = !(r_v3 && i_stall);
    assign o_stall = !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= pcms16_pkg::FMT_S16;
        end else if (i_cfg_we) begin
            r_fmt <= pcms16_pkg::t_fmt'(i_cfg_wdata);
        end
    end

    pcms16_decode u_decode (
        .i_bits   (i_sample_bits),
        .i_fmt    (r_fmt),
        .i_silent (i_silent),
        .i_last   (i_last_in_packet),
        .o_dec    (w_dec)
    );

    assign w_shifted = r_s1.sig >> r_s1.sh;

    // Half away from zero: add the fraction bit, then drop it.
    assign w_sum = {1'b0, r_q} + 17'd1;
    assign w_mag = w_sum[16:1];

    always_comb begin
        if (!r_f2) begin
            w_res = r_direct2;
        end else if (r_sign2) begin
            w_res = 16'(~w_mag + 16'd1);
        end else if (w_mag[15]) begin
            w_res = pcms16_pkg::PCM_MAX;
        end else begin
            w_res = w_mag;
        end
        if (r_silent2) begin
            w_res = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1      <= w_dec;
            r_q       <= w_shifted[15:0];
            r_f2      <= r_s1.is_float;
            r_sign2   <= r_s1.sign;
            r_direct2 <= r_s1.direct;
            r_silent2 <= r_s1.silent;
            r_last2   <= r_s1.last;
            r_pcm     <= w_res;
            r_last3   <= r_last2;
        end
    end

    assign o_valid              = r_v3;
    assign o_pcm16              = r_pcm;
    assign o_last_in_packet_res = r_last3;

endmodule
`default_nettype wire

// File: tb/sv/pcm_to_s16_converter_tb.sv
module pcm_to_s16_converter_tb;

    // One converted sample as it should leave the block.
    typedef struct {
        logic [15:0] pcm;
        logic        last;
    } t_pcm_out;

    // A row of the directed table. When known is set the expected sample is
    // typed in the row; otherwise it comes from the conversion predictor.
    typedef struct {
        pcms16_pkg::t_fmt fmt;
        logic [31:0] bits;
        logic        silent;
        logic        last;
        logic        known;
        logic [15:0] pcm;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_wdata = 2'd0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [31:0] i_sample_bits = 32'd0;
    logic        i_silent = 1'b0;
    logic        i_last_in_packet = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic signed [15:0] o_pcm16;
    logic        o_last_in_packet_res;

    t_pcm_out    pending_pcm[$];
    pcms16_pkg::t_fmt cur_fmt = pcms16_pkg::FMT_S16;
    int          error_count = 0;
    int          samples_sent = 0;
    int          samples_checked = 0;
    int          format_writes = 0;
    // When set, neither side inserts gaps or stalls.
    logic        full_rate = 1'b0;

    pcm_to_s16_converter dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_wdata          (i_cfg_wdata),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_sample_bits        (i_sample_bits),
        .i_silent             (i_silent),
        .i_last_in_packet     (i_last_in_packet),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_pcm16              (o_pcm16),
        .o_last_in_packet_res (o_last_in_packet_res)
    );

    always #5 i_clk = ~i_clk;

    // Integer model of the float path. A single float times 32768 is exact,
    // so the scaled magnitude is the 24-bit significand shifted right by
    // (135 - exponent), rounded half away from zero by adding half an LSB.
    function automatic logic [15:0] float_to_pcm(logic [31:0] bits);
        logic        sgn;
        logic [7:0]  ex;
        logic [47:0] sig;
        logic [47:0] mag;
        int          sh;
        sgn = bits[31];
        ex  = bits[30:23];
        if (ex == 8'hFF)
            return 16'h0000;
        if (ex >= 8'd127)
            return sgn ? 16'h8000 : 16'h7FFF;
        // Denormals have no hidden bit and the exponent of the smallest normal.
        sig = (ex == 8'd0) ? {25'd0, bits[22:0]} : {24'd0, 1'b1, bits[22:0]};
        sh  = (ex == 8'd0) ? 134 : 135 - int'(ex);
        if (sh > 40)
            mag = 48'd0;
        else
            mag = (sig + (48'd1 << (sh - 1))) >> sh;
        if (!sgn && mag > 48'd32767)
            return 16'h7FFF;
        return sgn ? 16'(-mag) : mag[15:0];
    endfunction

    function automatic logic [15:0] convert_sample(pcms16_pkg::t_fmt fmt, logic [31:0] bits,
                                                   logic silent);
        logic [15:0] v;
        case (fmt)
            pcms16_pkg::FMT_S16: v = bits[15:0];
            pcms16_pkg::FMT_S24: v = bits[23:8];
            pcms16_pkg::FMT_S32: v = bits[31:16];
            default: v = float_to_pcm(bits);
        endcase
        return silent ? 16'h0000 : v;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] want, logic [15:0] got);
        error_count++;
        $display("MISMATCH at %0t: %s expected %h got %h", $time, what, want, got);
    endtask

    // Gap length: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (full_rate || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Output stall: runs of random length so that stalls land on every
    // pipeline stage, including back-to-back items.
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else begin
            i_stall    <= full_rate ? 1'b0 : 1'(pick_gap() > 0);
            stall_left <= pick_gap();
        end
    end

    // Result checker: every accepted output item is matched against the
    // oldest expected sample.
    always @(posedge i_clk) begin
        t_pcm_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_pcm.size() == 0) begin
                report_mismatch("unexpected output item", 16'h0000, o_pcm16);
            end else begin
                want = pending_pcm.pop_front();
                samples_checked++;
                if (o_pcm16 !== want.pcm)
                    report_mismatch("pcm16", want.pcm, o_pcm16);
                if (o_last_in_packet_res !== want.last)
                    report_mismatch("last_in_packet", 16'(want.last),
                                    16'(o_last_in_packet_res));
            end
        end
    end

    // Drives one item after an optional gap and holds it until accepted.
    // Called at a rising edge; returns at the edge where the item was taken.
    task automatic send_sample(logic [31:0] bits, logic silent, logic last,
                               logic known, logic [15:0] typed);
        int       gap;
        t_pcm_out want;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_sample_bits    <= bits;
        i_silent         <= silent;
        i_last_in_packet <= last;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        want.pcm  = known ? typed : convert_sample(cur_fmt, bits, silent);
        want.last = last;
        pending_pcm.push_back(want);
        samples_sent++;
    endtask

    // Format changes happen only with the pipeline empty: drain, let the
    // three stages settle, then write the register for one cycle.
    task automatic set_format(pcms16_pkg::t_fmt fmt);
        i_valid <= 1'b0;
        while (pending_pcm.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= fmt;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_fmt = fmt;
        format_writes++;
    endtask

    function automatic logic [31:0] random_word(pcms16_pkg::t_fmt fmt);
        int k;
        if (fmt != pcms16_pkg::FMT_FLOAT)
            return $urandom;
        k = $urandom_range(0, 99);
        // Most floats sit in the audible range just under full scale.
        if (k < 70)
            return {1'($urandom), 8'($urandom_range(100, 127)), 23'($urandom)};
        if (k < 78)
            return {1'($urandom), 8'hFF, 23'($urandom)};
        if (k < 85)
            return {1'($urandom), 8'($urandom_range(127, 254)), 23'($urandom)};
        if (k < 90)
            return {1'($urandom), 8'd0, 23'($urandom)};
        return $urandom;
    endfunction

    t_row directed[] = '{
        // Passthrough extremes, with junk in the bits that the format does not use.
        '{pcms16_pkg::FMT_S16,   32'h1234_7FFF, 1'b0, 1'b0, 1'b1, 16'h7FFF},
        '{pcms16_pkg::FMT_S16,   32'hFFFF_8000, 1'b0, 1'b1, 1'b1, 16'h8000},
        '{pcms16_pkg::FMT_S16,   32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1, 16'h0000},
        '{pcms16_pkg::FMT_S24,   32'hAB7F_FFFF, 1'b0, 1'b0, 1'b1, 16'h7FFF},
        '{pcms16_pkg::FMT_S24,   32'h5480_0000, 1'b0, 1'b1, 1'b1, 16'h8000},
        '{pcms16_pkg::FMT_S24,   32'h0000_00FF, 1'b0, 1'b0, 1'b1, 16'h0000},
        '{pcms16_pkg::FMT_S32,   32'h7FFF_FFFF, 1'b0, 1'b0, 1'b1, 16'h7FFF},
        '{pcms16_pkg::FMT_S32,   32'h8000_0000, 1'b0, 1'b1, 1'b1, 16'h8000},
        '{pcms16_pkg::FMT_S32,   32'h8000_0000, 1'b1, 1'b0, 1'b1, 16'h0000},
        // Float full scale, beyond it, infinities, a NaN, negative zero and silence.
        '{pcms16_pkg::FMT_FLOAT, 32'h3F80_0000, 1'b0, 1'b0, 1'b1, 16'h7FFF},
        '{pcms16_pkg::FMT_FLOAT, 32'hBF80_0000, 1'b0, 1'b0, 1'b1, 16'h8000},
        '{pcms16_pkg::FMT_FLOAT, 32'h4000_0000, 1'b0, 1'b0, 1'b1, 16'h7FFF},
        '{pcms16_pkg::FMT_FLOAT, 32'hFF7F_FFFF, 1'b0, 1'b1, 1'b1, 16'h8000},
        '{pcms16_pkg::FMT_FLOAT, 32'h7F80_0000, 1'b0, 1'b0, 1'b1, 16'h0000},
        '{pcms16_pkg::FMT_FLOAT, 32'hFF80_0000, 1'b0, 1'b0, 1'b1, 16'h0000},
        '{pcms16_pkg::FMT_FLOAT, 32'hFFC0_0001, 1'b0, 1'b0, 1'b1, 16'h0000},
        '{pcms16_pkg::FMT_FLOAT, 32'h8000_0000, 1'b0, 1'b0, 1'b1, 16'h0000},
        '{pcms16_pkg::FMT_FLOAT, 32'h3F80_0000, 1'b1, 1'b1, 1'b1, 16'h0000},
        // Rounding near half an LSB, just under full scale, a denormal.
        '{pcms16_pkg::FMT_FLOAT, 32'h3F00_0000, 1'b0, 1'b0, 1'b0, 16'h0000},
        '{pcms16_pkg::FMT_FLOAT, 32'h3780_0000, 1'b0, 1'b0, 1'b0, 16'h0000},
        '{pcms16_pkg::FMT_FLOAT, 32'hB780_0000, 1'b0, 1'b0, 1'b0, 16'h0000},
        '{pcms16_pkg::FMT_FLOAT, 32'h377F_FFFF, 1'b0, 1'b0, 1'b0, 16'h0000},
        '{pcms16_pkg::FMT_FLOAT, 32'h3F7F_FFFF, 1'b0, 1'b0, 1'b0, 16'h0000},
        '{pcms16_pkg::FMT_FLOAT, 32'hBF7F_FFFF, 1'b0, 1'b0, 1'b0, 16'h0000},
        '{pcms16_pkg::FMT_FLOAT, 32'h807F_FFFF, 1'b0, 1'b1, 1'b0, 16'h0000}
    };

    // Random phases walk all formats; every third one, from the second on, runs at full rate.
    pcms16_pkg::t_fmt phase_fmt[] = '{
        pcms16_pkg::FMT_S16, pcms16_pkg::FMT_S24, pcms16_pkg::FMT_S32,
        pcms16_pkg::FMT_FLOAT, pcms16_pkg::FMT_S32, pcms16_pkg::FMT_FLOAT,
        pcms16_pkg::FMT_S24, pcms16_pkg::FMT_S16, pcms16_pkg::FMT_FLOAT
    };

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The first rows run on the reset format before anything is written.
        foreach (directed[r]) begin
            if (directed[r].fmt != cur_fmt)
                set_format(directed[r].fmt);
            send_sample(directed[r].bits, directed[r].silent, directed[r].last,
                        directed[r].known, directed[r].pcm);
        end

        foreach (phase_fmt[p]) begin
            set_format(phase_fmt[p]);
            full_rate = (p % 3 == 1);
            repeat (100) begin
                send_sample(random_word(cur_fmt), 1'($urandom_range(0, 9) == 0),
                            1'($urandom_range(0, 7) == 0), 1'b0, 16'h0000);
            end
        end
        full_rate = 1'b0;
        i_valid <= 1'b0;

        while (pending_pcm.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Sent %0d samples across %0d format writes; %0d results checked.",
                 samples_sent, format_writes, samples_checked);
        $display("Covered s16, s24, s32 and float input with silence and packet marks.");
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Hard stop in case the handshake hangs.
    initial begin
        #3000000;
        $display("Timeout with %0d results outstanding.", pending_pcm.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: files.f
rtl/pcms16_pkg.sv
rtl/pcms16_decode.sv
rtl/pcm_to_s16_converter.sv
tb/sv/pcm_to_s16_converter_tb.sv
